@@ rtl/abcs_pkg.sv @@
// ----------------------------------------------------------------------------
// abcs_pkg
// Types and constants of the accelerometer bias calibration sequencer:
// command and event codes, the phase state encoding and pipeline records.
// ----------------------------------------------------------------------------
package abcs_pkg;

	localparam int CMD_W   = 2;
	localparam int LOWG_W  = 20;
	localparam int HIGHG_W = 23;
	localparam int TOL_W   = 16;
	localparam int BIAS_W  = 24;
	localparam int SUM_W   = 32;
	localparam int CNT_W   = 7;
	localparam int PHASE_W = 3;
	localparam int EVT_W   = 3;
	localparam int DIST_W  = 22;

	localparam logic [TOL_W-1:0] TOL_RESET = 16'd786;

	// 1 g in Q16
	localparam logic signed [SUM_W-1:0] ONE_G = 32'sd65536;

	// result queue depth, also the number of items that may be in flight
	localparam int OUT_DEPTH = 8;
	localparam int PTR_W     = $clog2(OUT_DEPTH);
	localparam int OCC_W     = $clog2(OUT_DEPTH + 4) + 1;

	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ABORT  = 2'd2;

	typedef enum logic [EVT_W-1:0] {
		EVT_NONE  = 3'd0,
		EVT_READY = 3'd1,
		EVT_NEXT  = 3'd2,
		EVT_DONE  = 3'd3,
		EVT_ABORT = 3'd4
	} evt_t;

	typedef enum logic [6:0] {
		PH_IDLE  = 7'b0000001,
		PH_POS_X = 7'b0000010,
		PH_NEG_X = 7'b0000100,
		PH_POS_Y = 7'b0001000,
		PH_NEG_Y = 7'b0010000,
		PH_POS_Z = 7'b0100000,
		PH_NEG_Z = 7'b1000000
	} phase_t;

	// per-item record handed from the control stage to the bias stages
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		evt_t               evt;
		logic               accepted;
		logic               commit;
		logic               abort;
		logic               div_en;
		logic [1:0]         axis;
		logic               neg;
	} ctrl_t;

	typedef struct packed {
		logic [PHASE_W-1:0]       phase;
		evt_t                     evt;
		logic                     accepted;
		logic                     commit;
		logic signed [BIAS_W-1:0] bias_x;
		logic signed [BIAS_W-1:0] bias_y;
		logic signed [BIAS_W-1:0] bias_z;
	} res_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_W-1:0] code;
		case (ph)
			PH_IDLE:  code = 3'd0;
			PH_POS_X: code = 3'd1;
			PH_NEG_X: code = 3'd2;
			PH_POS_Y: code = 3'd3;
			PH_NEG_Y: code = 3'd4;
			PH_POS_Z: code = 3'd5;
			PH_NEG_Z: code = 3'd6;
			default:  code = 3'd0;
		endcase
		return code;
	endfunction

endpackage

@@ rtl/accel_bias_calibration_sequencer.sv @@
// ----------------------------------------------------------------------------
// accel_bias_calibration_sequencer
// Six-orientation bias calibration of a high-g accelerometer against a
// low-g reference, one result per input item.
// ----------------------------------------------------------------------------
// Usage: an input transfer (in_valid high, in_stall low) carries a command
// and one set of low-g and high-g readings. Every input transfer yields
// exactly one output transfer (out_valid high, out_stall low) carrying the
// phase, event, sample flag, commit flag and the working bias of all axes.
// The user writes accept_tolerance through cfg_we / cfg_wdata only while idle;
// the block itself does not enforce this. Throughput: one item per cycle
// while in_stall is low; the phase, count and sum update sits in the
// control stage, and the bias division (reciprocal multiply, then one
// correction) follows in two pipeline stages behind it.
// An eight-entry result queue decouples the sides: in_stall rises once
// eight accepted items have not yet been taken, so a stalling receiver
// stops the input within that margin and no result is lost.
// Reset (arst_n low) empties the pipeline and queue, returns to idle,
// clears count, sum, working and stored bias, and loads the tolerance
// with its default.
// ----------------------------------------------------------------------------
module accel_bias_calibration_sequencer #(
	parameter int SAMPLES_PER_SIDE = 50
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_we,
	input  logic [abcs_pkg::TOL_W-1:0]          cfg_wdata,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [abcs_pkg::CMD_W-1:0]          cmd,
	input  logic signed [abcs_pkg::LOWG_W-1:0]  lowg_x,
	input  logic signed [abcs_pkg::LOWG_W-1:0]  lowg_y,
	input  logic signed [abcs_pkg::LOWG_W-1:0]  lowg_z,
	input  logic signed [abcs_pkg::HIGHG_W-1:0] highg_x,
	input  logic signed [abcs_pkg::HIGHG_W-1:0] highg_y,
	input  logic signed [abcs_pkg::HIGHG_W-1:0] highg_z,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [abcs_pkg::PHASE_W-1:0]        phase,
	output logic [abcs_pkg::EVT_W-1:0]          event_res,
	output logic                                sample_accepted,
	output logic                                committed,
	output logic signed [abcs_pkg::BIAS_W-1:0]  bias_x,
	output logic signed [abcs_pkg::BIAS_W-1:0]  bias_y,
	output logic signed [abcs_pkg::BIAS_W-1:0]  bias_z
);

	localparam logic [7:0]  DIVISOR  = 8'(2 * SAMPLES_PER_SIDE);
	localparam logic [63:0] RECIP_W  = (64'd1 << 32) / 64'(DIVISOR);
	localparam logic [31:0] RECIP    = RECIP_W[31:0];
	localparam logic [abcs_pkg::CNT_W-1:0] CNT_END = abcs_pkg::CNT_W'(SAMPLES_PER_SIDE);

	// configuration
	logic [abcs_pkg::TOL_W-1:0] tol_q;

	// input stage
	logic                                v_s1;
	logic [abcs_pkg::CMD_W-1:0]          cmd_s1;
	logic signed [abcs_pkg::LOWG_W-1:0]  lowg_s1 [3];
	logic signed [abcs_pkg::HIGHG_W-1:0] highg_s1 [3];

	// control state
	abcs_pkg::phase_t                  phase_q;
	logic [abcs_pkg::CNT_W-1:0]        cnt_q;
	logic signed [abcs_pkg::SUM_W-1:0] sum_q;

	// bias state
	logic signed [abcs_pkg::BIAS_W-1:0] bias_q [3];
	logic signed [abcs_pkg::BIAS_W-1:0] stored_q [3];

	// pipeline after control
	logic            v_s2, v_s3;
	abcs_pkg::ctrl_t ctrl_s2, ctrl_s3;
	logic [31:0]     mag_s2, mag_s3;
	logic [31:0]     q0_s3;

	// result queue
	abcs_pkg::res_t                    fifo_q [abcs_pkg::OUT_DEPTH];
	logic [abcs_pkg::PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
	logic [abcs_pkg::PTR_W:0]          fifo_cnt_q;
	logic [abcs_pkg::OCC_W-1:0]        occ;
	logic                              accept, push, pop;

	// control stage signals
	abcs_pkg::phase_t                  phase_nx;
	logic [abcs_pkg::CNT_W-1:0]        cnt_nx, cnt_inc;
	logic signed [abcs_pkg::SUM_W-1:0] sum_nx, sum_add, nominal, term;
	logic signed [abcs_pkg::SUM_W-1:0] diff;
	logic [abcs_pkg::DIST_W-1:0]       err_mag;
	logic                              active, neg, hit;
	logic [1:0]                        axis;
	logic signed [abcs_pkg::LOWG_W-1:0]  lowg_sel;
	logic signed [abcs_pkg::HIGHG_W-1:0] highg_sel;
	abcs_pkg::ctrl_t                   ctrl_nx;
	logic [31:0]                       mag_nx;

	// division stage signals
	logic [63:0]                        prod;
	logic [39:0]                        rem;
	logic [31:0]                        quot, squot;
	logic signed [abcs_pkg::BIAS_W-1:0] bias_nx [3];
	abcs_pkg::res_t                     res;

	// ---------------- handshake and occupancy ----------------
	assign occ = abcs_pkg::OCC_W'(v_s1) + abcs_pkg::OCC_W'(v_s2) + abcs_pkg::OCC_W'(v_s3)
		+ abcs_pkg::OCC_W'(fifo_cnt_q);
	assign in_stall  = (occ >= abcs_pkg::OCC_W'(abcs_pkg::OUT_DEPTH));
	assign accept    = in_valid && !in_stall;
	assign out_valid = (fifo_cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign push      = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= abcs_pkg::TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// ---------------- input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd;
			lowg_s1[0]  <= lowg_x;
			lowg_s1[1]  <= lowg_y;
			lowg_s1[2]  <= lowg_z;
			highg_s1[0] <= highg_x;
			highg_s1[1] <= highg_y;
			highg_s1[2] <= highg_z;
		end
	end

	// ---------------- control stage ----------------
	always_comb begin
		active = 1'b1;
		neg    = 1'b0;
		axis   = 2'd0;
		case (phase_q)
			abcs_pkg::PH_POS_X: begin axis = 2'd0; neg = 1'b0; end
			abcs_pkg::PH_NEG_X: begin axis = 2'd0; neg = 1'b1; end
			abcs_pkg::PH_POS_Y: begin axis = 2'd1; neg = 1'b0; end
			abcs_pkg::PH_NEG_Y: begin axis = 2'd1; neg = 1'b1; end
			abcs_pkg::PH_POS_Z: begin axis = 2'd2; neg = 1'b0; end
			abcs_pkg::PH_NEG_Z: begin axis = 2'd2; neg = 1'b1; end
			default:            begin active = 1'b0; end
		endcase
	end

	always_comb begin
		case (axis)
			2'd1:    begin lowg_sel = lowg_s1[1]; highg_sel = highg_s1[1]; end
			2'd2:    begin lowg_sel = lowg_s1[2]; highg_sel = highg_s1[2]; end
			default: begin lowg_sel = lowg_s1[0]; highg_sel = highg_s1[0]; end
		endcase
	end

	assign nominal = neg ? -abcs_pkg::ONE_G : abcs_pkg::ONE_G;
	assign diff    = abcs_pkg::SUM_W'(lowg_sel) - nominal;
	assign err_mag = diff[abcs_pkg::SUM_W-1] ? abcs_pkg::DIST_W'(-diff)
		: abcs_pkg::DIST_W'(diff);
	assign hit     = (err_mag < abcs_pkg::DIST_W'(tol_q));
	assign term    = nominal - abcs_pkg::SUM_W'(highg_sel);
	assign sum_add = sum_q + term;
	assign cnt_inc = cnt_q + 1'b1;

	always_comb begin
		phase_nx         = phase_q;
		cnt_nx           = cnt_q;
		sum_nx           = sum_q;
		mag_nx           = '0;
		ctrl_nx.evt      = abcs_pkg::EVT_NONE;
		ctrl_nx.accepted = 1'b0;
		ctrl_nx.commit   = 1'b0;
		ctrl_nx.abort    = 1'b0;
		ctrl_nx.div_en   = 1'b0;
		ctrl_nx.axis     = axis;
		ctrl_nx.neg      = 1'b0;
		case (cmd_s1)
			abcs_pkg::CMD_BEGIN: begin
				if (phase_q == abcs_pkg::PH_IDLE) begin
					phase_nx    = abcs_pkg::PH_POS_X;
					cnt_nx      = '0;
					sum_nx      = '0;
					ctrl_nx.evt = abcs_pkg::EVT_READY;
				end
			end
			abcs_pkg::CMD_ABORT: begin
				phase_nx      = abcs_pkg::PH_IDLE;
				cnt_nx        = '0;
				sum_nx        = '0;
				ctrl_nx.evt   = abcs_pkg::EVT_ABORT;
				ctrl_nx.abort = 1'b1;
			end
			abcs_pkg::CMD_SAMPLE: begin
				if (active && hit) begin
					ctrl_nx.accepted = 1'b1;
					sum_nx           = sum_add;
					cnt_nx           = cnt_inc;
					if (cnt_inc >= CNT_END) begin
						cnt_nx = '0;
						if (neg) begin
							// end of a negative phase: hand the sum magnitude to the divider
							ctrl_nx.div_en = 1'b1;
							ctrl_nx.neg    = sum_add[abcs_pkg::SUM_W-1];
							mag_nx         = sum_add[abcs_pkg::SUM_W-1] ? 32'(-sum_add)
								: 32'(sum_add);
							sum_nx         = '0;
						end
						if (phase_q == abcs_pkg::PH_NEG_Z) begin
							phase_nx       = abcs_pkg::PH_IDLE;
							ctrl_nx.commit = 1'b1;
							ctrl_nx.evt    = abcs_pkg::EVT_DONE;
						end else begin
							// one-hot phases advance by a shift
							phase_nx    = abcs_pkg::phase_t'({phase_q[5:0], 1'b0});
							ctrl_nx.evt = abcs_pkg::EVT_NEXT;
						end
					end
				end
			end
			default: begin
			end
		endcase
		ctrl_nx.phase = abcs_pkg::phase_code(phase_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= abcs_pkg::PH_IDLE;
			cnt_q   <= '0;
			sum_q   <= '0;
			v_s2    <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			if (v_s1) begin
				phase_q <= phase_nx;
				cnt_q   <= cnt_nx;
				sum_q   <= sum_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s2 <= ctrl_nx;
		mag_s2  <= mag_nx;
	end

	// ---------------- reciprocal multiply ----------------
	assign prod = 64'(mag_s2) * 64'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s3 <= ctrl_s2;
		mag_s3  <= mag_s2;
		q0_s3   <= prod[63:32];
	end

	// ---------------- correction and bias update ----------------
	// the reciprocal estimate is at most one below the true quotient
	assign rem   = 40'(mag_s3) - 40'(q0_s3) * 40'(DIVISOR);
	assign quot  = (rem >= 40'(DIVISOR)) ? q0_s3 + 32'd1 : q0_s3;
	assign squot = ctrl_s3.neg ? 32'(-quot) : quot;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bias_nx[i] = bias_q[i];
		end
		if (ctrl_s3.abort) begin
			for (int i = 0; i < 3; i++) begin
				bias_nx[i] = stored_q[i];
			end
		end else if (ctrl_s3.div_en) begin
			bias_nx[ctrl_s3.axis] = squot[abcs_pkg::BIAS_W-1:0];
		end
	end

	always_comb begin
		res.phase    = ctrl_s3.phase;
		res.evt      = ctrl_s3.evt;
		res.accepted = ctrl_s3.accepted;
		res.commit   = ctrl_s3.commit;
		res.bias_x   = bias_nx[0];
		res.bias_y   = bias_nx[1];
		res.bias_z   = bias_nx[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				bias_q[i]   <= '0;
				stored_q[i] <= '0;
			end
		end else if (v_s3) begin
			for (int i = 0; i < 3; i++) begin
				bias_q[i] <= bias_nx[i];
				if (ctrl_s3.commit) begin
					stored_q[i] <= bias_nx[i];
				end
			end
		end
	end

	// ---------------- result queue ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + 1'b1;
				2'b01:   fifo_cnt_q <= fifo_cnt_q - 1'b1;
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	assign phase           = fifo_q[rd_ptr_q].phase;
	assign event_res       = fifo_q[rd_ptr_q].evt;
	assign sample_accepted = fifo_q[rd_ptr_q].accepted;
	assign committed       = fifo_q[rd_ptr_q].commit;
	assign bias_x          = fifo_q[rd_ptr_q].bias_x;
	assign bias_y          = fifo_q[rd_ptr_q].bias_y;
	assign bias_z          = fifo_q[rd_ptr_q].bias_z;

`ifndef SYNTH
	// a result never lands in a full queue unless one leaves in the same cycle
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_cnt_q != (abcs_pkg::PTR_W+1)'(abcs_pkg::OUT_DEPTH)) || pop)
		else $error("result queue overflow");

	// items in flight never exceed the queue capacity
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= abcs_pkg::OCC_W'(abcs_pkg::OUT_DEPTH))
		else $error("occupancy beyond queue depth");

	// a commit only comes with the completion event and a return to idle
	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && committed |-> (event_res == abcs_pkg::EVT_DONE) && (phase == '0))
		else $error("commit without completion");

	// a division result is only produced at the end of a negative phase sample
	a_div_sample: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && ctrl_s3.div_en |-> ctrl_s3.accepted
			&& (ctrl_s3.evt == abcs_pkg::EVT_NEXT || ctrl_s3.evt == abcs_pkg::EVT_DONE))
		else $error("bias division outside phase end");
`endif

endmodule
